>>> hw/rtl/trs_pkg.sv
// Shared types and constants for the tracker row tempo sequencer.
// No dependencies; used by trs_step and tracker_row_tempo_sequencer_top.
`default_nettype none

package trs_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [0:0] REG_LAST_ORDER = 1'b0;

    localparam logic [8:0] FRAME_ONE   = 9'h008;
    localparam logic [7:0] SPEED_LO    = 8'h08;
    localparam logic [7:0] SPEED_HI    = 8'hF8;
    localparam logic [7:0] SPEED_RESET = 8'h30;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_NEXT  = 2'd1,
        ST_JUMP  = 2'd2,
        ST_HALT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REQ_EFFECT = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_LOAD   = 2'd2,
        REQ_SPEED  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        FX_GOTO  = 3'd0,
        FX_HALT  = 3'd1,
        FX_SKIP  = 3'd2,
        FX_TEMPO = 3'd3
    } effect_t;

    typedef struct packed {
        logic [8:0] frame_count;
        logic [7:0] speed;
        logic [7:0] row_pos;
        status_t    status_now;
        status_t    status_pending;
        logic [7:0] jump;
    } seq_state_t;

    typedef struct packed {
        status_t    play_status;
        logic [7:0] jump_target;
        logic       row_started;
        logic [7:0] current_row;
        logic [7:0] current_speed;
        logic       rejected;
    } seq_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/trs_step.sv
// Next-state and result logic for one sequencer beat.
// Depends on trs_pkg.
`default_nettype none

module trs_step (
    input  wire trs_pkg::seq_state_t  cur,
    input  wire logic [8:0]           row_total,
    input  wire logic [7:0]           last_order,
    input  wire logic [1:0]           req_type,
    input  wire logic [2:0]           effect_kind,
    input  wire logic [7:0]           effect_value,
    input  wire logic [8:0]           pattern_rows,
    input  wire logic [7:0]           new_speed,
    output trs_pkg::seq_state_t       nxt,
    output logic [8:0]                row_total_next,
    output trs_pkg::seq_result_t      res
);

    logic [8:0] fc_add;
    logic [8:0] speed_ext;
    logic [8:0] row_inc;
    logic       started;
    logic       rej;

    assign fc_add    = cur.frame_count + trs_pkg::FRAME_ONE;
    assign speed_ext = {1'b0, cur.speed};
    assign row_inc   = {1'b0, cur.row_pos} + 9'd1;

    always_comb
    begin
        nxt            = cur;
        row_total_next = row_total;
        started        = 1'b0;
        rej            = 1'b0;
        unique case (trs_pkg::req_t'(req_type))
            trs_pkg::REQ_EFFECT:
            begin
                if (cur.status_now == trs_pkg::ST_READY &&
                    cur.frame_count < trs_pkg::FRAME_ONE)
                begin
                    case (effect_kind)
                        trs_pkg::FX_GOTO:
                        begin
                            if (effect_value <= last_order)
                            begin
                                nxt.status_pending = trs_pkg::ST_JUMP;
                                nxt.jump           = effect_value;
                            end
                        end
                        trs_pkg::FX_HALT:
                        begin
                            nxt.status_now     = trs_pkg::ST_HALT;
                            nxt.status_pending = trs_pkg::ST_HALT;
                        end
                        trs_pkg::FX_SKIP:
                        begin
                            nxt.status_pending = trs_pkg::ST_NEXT;
                        end
                        trs_pkg::FX_TEMPO:
                        begin
                            if (effect_value >= trs_pkg::SPEED_LO &&
                                effect_value <= trs_pkg::SPEED_HI)
                            begin
                                nxt.speed = effect_value;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            trs_pkg::REQ_TICK:
            begin
                if (cur.status_now != trs_pkg::ST_READY)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    started = (cur.frame_count < trs_pkg::FRAME_ONE);
                    if (fc_add >= speed_ext)
                    begin
                        nxt.frame_count = fc_add - speed_ext;
                        if (row_inc >= row_total || row_inc[8])
                        begin
                            nxt.status_now = (cur.status_pending == trs_pkg::ST_READY) ?
                                             trs_pkg::ST_NEXT : cur.status_pending;
                        end
                        else
                        begin
                            nxt.row_pos    = row_inc[7:0];
                            nxt.status_now = cur.status_pending;
                        end
                        nxt.status_pending = trs_pkg::ST_READY;
                    end
                    else
                    begin
                        nxt.frame_count = fc_add;
                    end
                end
            end
            trs_pkg::REQ_LOAD:
            begin
                nxt.row_pos    = 8'd0;
                row_total_next = pattern_rows;
                nxt.status_now = trs_pkg::ST_READY;
            end
            trs_pkg::REQ_SPEED:
            begin
                if (new_speed < trs_pkg::SPEED_LO || new_speed > trs_pkg::SPEED_HI)
                    rej = 1'b1;
                else
                    nxt.speed = new_speed;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.play_status   = nxt.status_now;
        res.jump_target   = nxt.jump;
        res.row_started   = started;
        res.current_row   = nxt.row_pos;
        res.current_speed = nxt.speed;
        res.rejected      = rej;
    end

endmodule

`default_nettype wire

>>> hw/rtl/tracker_row_tempo_sequencer_top.sv
// Throughput: one beat per cycle while in_ready is high; state updates at acceptance.
// Results go to a two-entry output buffer (output register plus skid); a result is parked
// in the skid only when the output is stalled, so in_ready drops only when both are full.
// Reset: rst_n asynchronous, active low; counter, row and jump clear, speed 0x30,
// status ready, last_order 0. Row total holds no value until a pattern load.
`default_nettype none

module tracker_row_tempo_sequencer_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [trs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [trs_pkg::DATA_W-1:0]   pwdata,
    output logic [trs_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   req_type,
    input  wire logic [2:0]                   effect_kind,
    input  wire logic [7:0]                   effect_value,
    input  wire logic [8:0]                   pattern_rows,
    input  wire logic [7:0]                   new_speed,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        play_status,
    output logic [7:0]                        jump_target,
    output logic                              row_started,
    output logic [7:0]                        current_row,
    output logic [7:0]                        current_speed,
    output logic                              rejected
);

    trs_pkg::seq_state_t  state_reg;
    trs_pkg::seq_state_t  state_next;
    logic [8:0]           row_total_reg;
    logic [8:0]           row_total_next;
    logic [7:0]           last_order_reg;
    trs_pkg::seq_result_t step_res;
    trs_pkg::seq_result_t out_reg;
    trs_pkg::seq_result_t skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic                 in_fire;
    logic                 out_fire;
    logic                 cfg_wr;
    logic                 cfg_hit;

    assign pready   = 1'b1;
    assign cfg_hit  = (paddr[2] == trs_pkg::REG_LAST_ORDER);
    assign cfg_wr   = psel && penable && pwrite && pready && cfg_hit;
    assign prdata   = cfg_hit ? {{(trs_pkg::DATA_W-8){1'b0}}, last_order_reg}
                              : '0;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_fire  = out_valid_reg && out_ready;

    trs_step u_step (
        .cur            (state_reg),
        .row_total      (row_total_reg),
        .last_order     (last_order_reg),
        .req_type       (req_type),
        .effect_kind    (effect_kind),
        .effect_value   (effect_value),
        .pattern_rows   (pattern_rows),
        .new_speed      (new_speed),
        .nxt            (state_next),
        .row_total_next (row_total_next),
        .res            (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_order_reg <= 8'd0;
        end
        else if (cfg_wr)
        begin
            last_order_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.frame_count    <= 9'd0;
            state_reg.speed          <= trs_pkg::SPEED_RESET;
            state_reg.row_pos        <= 8'd0;
            state_reg.status_now     <= trs_pkg::ST_READY;
            state_reg.status_pending <= trs_pkg::ST_READY;
            state_reg.jump           <= 8'd0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            row_total_reg <= row_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
                skid_reg <= step_res;
            else
                out_reg <= step_res;
        end
    end

    assign play_status   = out_reg.play_status;
    assign jump_target   = out_reg.jump_target;
    assign row_started   = out_reg.row_started;
    assign current_row   = out_reg.current_row;
    assign current_speed = out_reg.current_speed;
    assign rejected      = out_reg.rejected;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("beat accepted under stall not parked in skid");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.speed >= trs_pkg::SPEED_LO && state_reg.speed <= trs_pkg::SPEED_HI))
        else $error("speed left legal range");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.status_now == trs_pkg::ST_HALT &&
         !(in_fire && req_type == trs_pkg::REQ_LOAD))
        |=> state_reg.status_now == trs_pkg::ST_HALT)
        else $error("halt cleared without pattern load");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tracker_row_tempo_sequencer_checker.sv
`timescale 1ns / 100ps
// Playback checker for tracker_row_tempo_sequencer_top: tracks row, tempo and status state,
// predicts one result beat per accepted request beat and compares results in order.
// Depends on trs_pkg for request, effect and status codes and the result layout.
module tracker_row_tempo_sequencer_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [trs_pkg::ADDR_W-1:0]   paddr,
    input  logic [trs_pkg::DATA_W-1:0]   pwdata,
    input  logic                         pready,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [1:0]                   req_type,
    input  logic [2:0]                   effect_kind,
    input  logic [7:0]                   effect_value,
    input  logic [8:0]                   pattern_rows,
    input  logic [7:0]                   new_speed,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [1:0]                   play_status,
    input  logic [7:0]                   jump_target,
    input  logic                         row_started,
    input  logic [7:0]                   current_row,
    input  logic [7:0]                   current_speed,
    input  logic                         rejected,
    output int                           outstanding,
    output int                           errors,
    output int                           checked_beats,
    output int                           row_starts,
    output int                           reject_beats
);

    localparam logic [trs_pkg::ADDR_W-1:0] LAST_ORDER_ADDR = {trs_pkg::REG_LAST_ORDER, 2'b00};

    logic [7:0]       last_order;
    logic [8:0]       frame_cnt;
    logic [7:0]       speed;
    logic [7:0]       row_pos;
    logic [8:0]       row_total;
    trs_pkg::status_t status_now;
    trs_pkg::status_t status_queued;
    logic [7:0]       jump_to;

    trs_pkg::seq_result_t pending_playback[$];
    trs_pkg::seq_result_t want;
    trs_pkg::seq_result_t got;

    int fail_cnt   = 0;
    int beat_cnt   = 0;
    int start_cnt  = 0;
    int reject_cnt = 0;

    assign errors        = fail_cnt;
    assign checked_beats = beat_cnt;
    assign row_starts    = start_cnt;
    assign reject_beats  = reject_cnt;

    function automatic trs_pkg::seq_result_t playback_step(input logic [1:0] req,
                                                           input logic [2:0] kind,
                                                           input logic [7:0] value,
                                                           input logic [8:0] rows,
                                                           input logic [7:0] spd);
        trs_pkg::seq_result_t res;
        logic [8:0]           nxt;
        res = '0;
        case (req)
            trs_pkg::REQ_EFFECT:
            begin
                if (status_now == trs_pkg::ST_READY && frame_cnt < trs_pkg::FRAME_ONE)
                begin
                    case (kind)
                        trs_pkg::FX_GOTO:
                        begin
                            if (value <= last_order)
                            begin
                                status_queued = trs_pkg::ST_JUMP;
                                jump_to = value;
                            end
                        end
                        trs_pkg::FX_HALT:
                        begin
                            status_now = trs_pkg::ST_HALT;
                            status_queued = trs_pkg::ST_HALT;
                        end
                        trs_pkg::FX_SKIP:
                        begin
                            status_queued = trs_pkg::ST_NEXT;
                        end
                        trs_pkg::FX_TEMPO:
                        begin
                            if (value >= trs_pkg::SPEED_LO && value <= trs_pkg::SPEED_HI)
                                speed = value;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            trs_pkg::REQ_TICK:
            begin
                if (status_now != trs_pkg::ST_READY)
                    res.rejected = 1'b1;
                else
                begin
                    res.row_started = (frame_cnt < trs_pkg::FRAME_ONE);
                    frame_cnt = frame_cnt + trs_pkg::FRAME_ONE;
                    if (frame_cnt >= {1'b0, speed})
                    begin
                        // take off at most one row length per frame
                        frame_cnt = frame_cnt - {1'b0, speed};
                        nxt = {1'b0, row_pos} + 9'd1;
                        if (nxt >= row_total || nxt[8])
                            status_now = (status_queued == trs_pkg::ST_READY) ?
                                         trs_pkg::ST_NEXT : status_queued;
                        else
                        begin
                            row_pos = nxt[7:0];
                            status_now = status_queued;
                        end
                        status_queued = trs_pkg::ST_READY;
                    end
                end
            end
            trs_pkg::REQ_LOAD:
            begin
                row_pos = 8'd0;
                row_total = rows;
                status_now = trs_pkg::ST_READY;
            end
            default:
            begin
                if (spd < trs_pkg::SPEED_LO || spd > trs_pkg::SPEED_HI)
                    res.rejected = 1'b1;
                else
                    speed = spd;
            end
        endcase
        res.play_status   = status_now;
        res.jump_target   = jump_to;
        res.current_row   = row_pos;
        res.current_speed = speed;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_order    = 8'd0;
            frame_cnt     = 9'd0;
            speed         = trs_pkg::SPEED_RESET;
            row_pos       = 8'd0;
            row_total     = 9'd0;
            status_now    = trs_pkg::ST_READY;
            status_queued = trs_pkg::ST_READY;
            jump_to       = 8'd0;
            pending_playback.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LAST_ORDER_ADDR)
                last_order = pwdata[7:0];
            if (out_valid && out_ready)
            begin
                got = {play_status, jump_target, row_started, current_row, current_speed,
                       rejected};
                if (pending_playback.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h", $time, got);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_playback.pop_front();
                    beat_cnt++;
                    if (got !== want)
                    begin
                        $display({"%0t: expected status=%0d jump=%h start=%b row=%h speed=%h ",
                                  "rej=%b, actual status=%0d jump=%h start=%b row=%h speed=%h ",
                                  "rej=%b"},
                                 $time, want.play_status, want.jump_target, want.row_started,
                                 want.current_row, want.current_speed, want.rejected,
                                 play_status, jump_target, row_started, current_row,
                                 current_speed, rejected);
                        fail_cnt++;
                    end
                    if (want.row_started)
                        start_cnt++;
                    if (want.rejected)
                        reject_cnt++;
                end
            end
            if (in_valid && in_ready)
                pending_playback.push_back(playback_step(req_type, effect_kind, effect_value,
                                                         pattern_rows, new_speed));
            outstanding <= pending_playback.size();
        end
    end

endmodule

>>> tb/sv/tracker_row_tempo_sequencer_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for tracker_row_tempo_sequencer_top: drives request beats, APB writes
// and output backpressure, and gives the verdict from tracker_row_tempo_sequencer_checker.
// Depends on trs_pkg, the block and the checker.
module tracker_row_tempo_sequencer_top_tb;

    localparam logic [trs_pkg::ADDR_W-1:0] LAST_ORDER_ADDR = {trs_pkg::REG_LAST_ORDER, 2'b00};

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       psel         = 1'b0;
    logic                       penable      = 1'b0;
    logic                       pwrite       = 1'b0;
    logic [trs_pkg::ADDR_W-1:0] paddr        = '0;
    logic [trs_pkg::DATA_W-1:0] pwdata       = '0;
    logic [trs_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic [1:0]                 req_type     = 2'd0;
    logic [2:0]                 effect_kind  = 3'd0;
    logic [7:0]                 effect_value = 8'd0;
    logic [8:0]                 pattern_rows = 9'd1;
    logic [7:0]                 new_speed    = 8'd0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic [1:0]                 play_status;
    logic [7:0]                 jump_target;
    logic                       row_started;
    logic [7:0]                 current_row;
    logic [7:0]                 current_speed;
    logic                       rejected;

    int outstanding;
    int errors;
    int checked_beats;
    int row_starts;
    int reject_beats;

    int         idle_pct  = 0;
    int         stall_pct = 0;
    logic [7:0] cur_last_order = 8'd0;
    int         idle_plan[4]  = '{0, 58, 0, 10};
    int         stall_plan[4] = '{0, 0, 58, 10};

    tracker_row_tempo_sequencer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .effect_kind   (effect_kind),
        .effect_value  (effect_value),
        .pattern_rows  (pattern_rows),
        .new_speed     (new_speed),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .play_status   (play_status),
        .jump_target   (jump_target),
        .row_started   (row_started),
        .current_row   (current_row),
        .current_speed (current_speed),
        .rejected      (rejected)
    );

    tracker_row_tempo_sequencer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .effect_kind   (effect_kind),
        .effect_value  (effect_value),
        .pattern_rows  (pattern_rows),
        .new_speed     (new_speed),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .play_status   (play_status),
        .jump_target   (jump_target),
        .row_started   (row_started),
        .current_row   (current_row),
        .current_speed (current_speed),
        .rejected      (rejected),
        .outstanding   (outstanding),
        .errors        (errors),
        .checked_beats (checked_beats),
        .row_starts    (row_starts),
        .reject_beats  (reject_beats)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_beat(input logic [1:0] req, input logic [2:0] kind,
                             input logic [7:0] value, input logic [8:0] rows,
                             input logic [7:0] spd);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        req_type     <= req;
        effect_kind  <= kind;
        effect_value <= value;
        pattern_rows <= rows;
        new_speed    <= spd;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic random_beat;
        int         pick;
        logic [1:0] req;
        logic [2:0] kind;
        logic [7:0] value;
        logic [8:0] rows;
        logic [7:0] spd;
        pick  = $urandom_range(99);
        req   = (pick < 45) ? trs_pkg::REQ_TICK : (pick < 70) ? trs_pkg::REQ_EFFECT :
                (pick < 85) ? trs_pkg::REQ_LOAD : trs_pkg::REQ_SPEED;
        kind  = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        value = 8'($urandom);
        if (kind == trs_pkg::FX_GOTO && $urandom_range(1) == 1)
            value = 8'($urandom_range(0, cur_last_order));
        if (kind == trs_pkg::FX_TEMPO && $urandom_range(2) != 0)
            value = 8'($urandom_range(trs_pkg::SPEED_LO, 8'h40));
        rows  = ($urandom_range(7) == 0) ? 9'($urandom_range(1, 256)) : 9'($urandom_range(1, 8));
        spd   = ($urandom_range(4) == 0) ? 8'($urandom) :
                8'($urandom_range(trs_pkg::SPEED_LO, 8'h30));
        send_beat(req, kind, value, rows, spd);
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_last_order(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LAST_ORDER_ADDR;
        pwdata  <= {{(trs_pkg::DATA_W - 8){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_last_order = value;
    endtask

    initial
    begin
        #200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_last_order(8'd5);

        send_beat(trs_pkg::REQ_SPEED,  3'd0, 8'h00, 9'd1, 8'h07);
        send_beat(trs_pkg::REQ_SPEED,  3'd0, 8'h00, 9'd1, 8'hF9);
        send_beat(trs_pkg::REQ_SPEED,  3'd0, 8'h00, 9'd1, 8'hFF);
        send_beat(trs_pkg::REQ_SPEED,  3'd0, 8'h00, 9'd1, trs_pkg::SPEED_LO);
        send_beat(trs_pkg::REQ_LOAD,   3'd0, 8'h00, 9'd3, 8'h00);
        send_beat(trs_pkg::REQ_EFFECT, trs_pkg::FX_GOTO, 8'd6, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_EFFECT, trs_pkg::FX_GOTO, 8'd5, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_TICK,   3'd0, 8'h00, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_TICK,   3'd0, 8'h00, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_EFFECT, trs_pkg::FX_SKIP, 8'h00, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_LOAD,   3'd0, 8'h00, 9'd256, 8'h00);
        send_beat(trs_pkg::REQ_EFFECT, 3'd4, 8'hFF, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_EFFECT, 3'd7, 8'h00, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_EFFECT, trs_pkg::FX_TEMPO, 8'h07, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_EFFECT, trs_pkg::FX_TEMPO, 8'hF9, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_EFFECT, trs_pkg::FX_TEMPO, trs_pkg::SPEED_HI, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_TICK,   3'd0, 8'h00, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_EFFECT, trs_pkg::FX_SKIP, 8'h00, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_SPEED,  3'd0, 8'h00, 9'd1, trs_pkg::SPEED_LO);
        send_beat(trs_pkg::REQ_TICK,   3'd0, 8'h00, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_LOAD,   3'd0, 8'h00, 9'd0, 8'h00);
        send_beat(trs_pkg::REQ_TICK,   3'd0, 8'h00, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_SPEED,  3'd0, 8'h00, 9'd1, 8'h10);
        send_beat(trs_pkg::REQ_LOAD,   3'd0, 8'h00, 9'h1FF, 8'h00);
        send_beat(trs_pkg::REQ_TICK,   3'd0, 8'h00, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_EFFECT, trs_pkg::FX_HALT, 8'h00, 9'd1, 8'h00);
        send_beat(trs_pkg::REQ_TICK,   3'd0, 8'h00, 9'd1, 8'h00);

        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            case (ph)
                0: write_last_order(8'h00);
                1: write_last_order(8'hFF);
                default: write_last_order(8'($urandom_range(1, 254)));
            endcase
            idle_pct = idle_plan[ph];
            stall_pct <= stall_plan[ph];
            if (ph == 2)
            begin
                // walk a full-length pattern to the last row at one frame per row
                send_beat(trs_pkg::REQ_SPEED, 3'd0, 8'h00, 9'd1, trs_pkg::SPEED_LO);
                send_beat(trs_pkg::REQ_LOAD, 3'd0, 8'h00, 9'h1FF, 8'h00);
                repeat (256)
                    send_beat(trs_pkg::REQ_TICK, 3'd0, 8'h00, 9'd1, 8'h00);
            end
            repeat (30)
                random_beat();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Covered %0d result beats (%0d row starts, %0d rejected requests)",
                 checked_beats, row_starts, reject_beats);
        $display("over directed edge cases, a 256-row walk and four handshake pressure phases");
        if (errors == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/trs_pkg.sv
hw/rtl/trs_step.sv
hw/rtl/tracker_row_tempo_sequencer_top.sv
tb/sv/tracker_row_tempo_sequencer_checker.sv
tb/sv/tracker_row_tempo_sequencer_top_tb.sv
